// File: design/mwsm_pkg.sv
package mwsm_pkg;

   localparam int SPEED_W = 16;
   localparam int LIMIT_W = 15;
   localparam int RATIO_W = 32;
   localparam int MAG_W = 16;
   localparam int WHEELS = 4;
   localparam int DEF_RATIO_FRAC_BITS = 24;

   // Front pipeline depth in register stages, and the request queue between the halves.
   localparam int FRONT_LAT = 6;
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_LIMIT_FORWARD = 3'd0;
   localparam logic [2:0] REG_LIMIT_SIDEWAYS = 3'd1;
   localparam logic [2:0] REG_LIMIT_TURN = 3'd2;
   localparam logic [2:0] REG_LIMIT_WHEEL_RPM = 3'd3;
   localparam logic [2:0] REG_TURN_GAIN_FRONT = 3'd4;
   localparam logic [2:0] REG_TURN_GAIN_BACK = 3'd5;
   localparam logic [2:0] REG_RPM_PER_SPEED = 3'd6;

   localparam logic [LIMIT_W-1:0] LIMIT_FORWARD_RESET = 15'd3500;
   localparam logic [LIMIT_W-1:0] LIMIT_SIDEWAYS_RESET = 15'd3500;
   localparam logic [LIMIT_W-1:0] LIMIT_TURN_RESET = 15'd300;
   localparam logic [LIMIT_W-1:0] LIMIT_WHEEL_RPM_RESET = 15'd8500;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit_forward;
      logic [LIMIT_W-1:0] limit_sideways;
      logic [LIMIT_W-1:0] limit_turn;
      logic [LIMIT_W-1:0] limit_wheel_rpm;
      logic [RATIO_W-1:0] turn_gain_front;
      logic [RATIO_W-1:0] turn_gain_back;
      logic [RATIO_W-1:0] rpm_per_speed;
   } cfg_type;

   // One mixed request: saturated wheel magnitudes with signs, their maximum,
   // and whether the back half must rescale them.
   typedef struct packed {
      logic [WHEELS-1:0] neg;
      logic [WHEELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0] maxm;
      logic scale;
   } wheel_item_type;

endpackage

// File: design/mwsm_front.sv
module mwsm_front #(
   parameter int RATIO_FRAC_BITS = mwsm_pkg::DEF_RATIO_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [mwsm_pkg::SPEED_W-1:0] speed_forward,
   input  logic signed [mwsm_pkg::SPEED_W-1:0] speed_sideways,
   input  logic signed [mwsm_pkg::SPEED_W-1:0] turn_rate,
   input  mwsm_pkg::cfg_type cfg,
   output logic out_valid,
   output mwsm_pkg::wheel_item_type out_item
);
   import mwsm_pkg::*;

   localparam int LIN_W = SPEED_W + 1;
   localparam int PROD_W = SPEED_W + RATIO_W + 1;
   localparam int SHL_W = LIN_W + RATIO_FRAC_BITS;
   localparam int ACC_W = ((SHL_W > PROD_W) ? SHL_W : PROD_W) + 1;
   localparam int HI_W = ACC_W - RATIO_W;
   localparam int FULL_W = ACC_W + RATIO_W;
   localparam int QF_W = FULL_W - 2 * RATIO_FRAC_BITS;

   function automatic logic signed [SPEED_W-1:0] clamp_sym(
      input logic signed [SPEED_W-1:0] v, input logic [LIMIT_W-1:0] lim);
      logic signed [SPEED_W:0] l;
      logic signed [SPEED_W:0] x;
      l = signed'({2'b00, lim});
      x = (SPEED_W + 1)'(v);
      if (x > l) begin
         clamp_sym = l[SPEED_W-1:0];
      end else if (x < -l) begin
         clamp_sym = SPEED_W'(-l);
      end else begin
         clamp_sym = v;
      end
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [LIN_W-1:0] lin1_ff [WHEELS];
   logic signed [SPEED_W-1:0] turn1_ff;
   logic signed [LIN_W-1:0] lin2_ff [WHEELS];
   logic signed [PROD_W-1:0] prodf2_ff, prodb2_ff;
   logic [ACC_W-1:0] m3_ff [WHEELS];
   logic [WHEELS-1:0] neg3_ff, neg4_ff, neg5_ff;
   logic [2*RATIO_W-1:0] plo4_ff [WHEELS];
   logic [HI_W+RATIO_W-1:0] phi4_ff [WHEELS];
   logic [MAG_W-1:0] mag5_ff [WHEELS];
   wheel_item_type item6_ff;

   logic signed [SPEED_W-1:0] fwd_c, side_c, turn_c;
   logic signed [LIN_W-1:0] lin_in [WHEELS];
   logic signed [ACC_W-1:0] acc_c [WHEELS];
   logic [FULL_W-1:0] full_c [WHEELS];
   logic [QF_W-1:0] qf_c [WHEELS];
   logic [MAG_W-1:0] mag_in [WHEELS];
   logic [MAG_W-1:0] m01_c, m23_c, mx_c;

   always_comb begin
      fwd_c = clamp_sym(speed_forward, cfg.limit_forward);
      side_c = clamp_sym(speed_sideways, cfg.limit_sideways);
      turn_c = clamp_sym(turn_rate, cfg.limit_turn);
      lin_in[0] = LIN_W'(fwd_c) - LIN_W'(side_c);
      lin_in[1] = LIN_W'(fwd_c) + LIN_W'(side_c);
      lin_in[2] = LIN_W'(side_c) - LIN_W'(fwd_c);
      lin_in[3] = -LIN_W'(fwd_c) - LIN_W'(side_c);
   end

   always_comb begin
      for (int l = 0; l < WHEELS; l++) begin
         acc_c[l] = (ACC_W'(lin2_ff[l]) <<< RATIO_FRAC_BITS)
                  + ACC_W'((l < 2) ? prodf2_ff : prodb2_ff);
         full_c[l] = {phi4_ff[l], {RATIO_W{1'b0}}} + FULL_W'(plo4_ff[l]);
         qf_c[l] = full_c[l][FULL_W-1:2*RATIO_FRAC_BITS];
         // Truncation already happened on the magnitude; clip to the 16-bit range.
         if (neg4_ff[l]) begin
            mag_in[l] = (qf_c[l] > QF_W'(32768)) ? 16'h8000 : qf_c[l][MAG_W-1:0];
         end else begin
            mag_in[l] = (qf_c[l] > QF_W'(32767)) ? 16'h7FFF : qf_c[l][MAG_W-1:0];
         end
      end
      m01_c = (mag5_ff[0] > mag5_ff[1]) ? mag5_ff[0] : mag5_ff[1];
      m23_c = (mag5_ff[2] > mag5_ff[3]) ? mag5_ff[2] : mag5_ff[3];
      mx_c = (m01_c > m23_c) ? m01_c : m23_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      turn1_ff <= turn_c;
      prodf2_ff <= turn1_ff * signed'({1'b0, cfg.turn_gain_front});
      prodb2_ff <= turn1_ff * signed'({1'b0, cfg.turn_gain_back});
      for (int l = 0; l < WHEELS; l++) begin
         lin1_ff[l] <= lin_in[l];
         lin2_ff[l] <= lin1_ff[l];
         neg3_ff[l] <= acc_c[l][ACC_W-1];
         m3_ff[l] <= acc_c[l][ACC_W-1] ? ACC_W'(-acc_c[l]) : ACC_W'(acc_c[l]);
         plo4_ff[l] <= m3_ff[l][RATIO_W-1:0] * cfg.rpm_per_speed;
         phi4_ff[l] <= m3_ff[l][ACC_W-1:RATIO_W] * cfg.rpm_per_speed;
         mag5_ff[l] <= mag_in[l];
         item6_ff.mag[l] <= mag5_ff[l];
      end
      neg4_ff <= neg3_ff;
      neg5_ff <= neg4_ff;
      item6_ff.neg <= neg5_ff;
      item6_ff.maxm <= mx_c;
      item6_ff.scale <= mx_c > {1'b0, cfg.limit_wheel_rpm};
   end

   assign out_valid = v6_ff;
   assign out_item = item6_ff;

endmodule

// File: design/mwsm_queue.sv
module mwsm_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  mwsm_pkg::wheel_item_type push_item,
   input  logic pop,
   output mwsm_pkg::wheel_item_type pop_item,
   output logic pop_valid,
   output logic almost_full
);
   import mwsm_pkg::*;

   wheel_item_type mem_ff [QUEUE_DEPTH];
   wheel_item_type pop_item_ff;
   logic pop_valid_ff;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);
   // A popped request is read out of the memory into a register and is valid in the cycle after the pop.
   assign pop_valid = pop_valid_ff;
   assign pop_item = pop_item_ff;
   // Leave room for every request still travelling through the front pipeline.
   assign almost_full = (count_ff >= COUNT_W'(QUEUE_DEPTH - FRONT_LAT));

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pop_valid_ff <= do_pop;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
      if (do_pop) begin
         pop_item_ff <= mem_ff[rd_ptr_ff];
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !do_pop && (count_ff == COUNT_W'(QUEUE_DEPTH))))
      else $error("request queue overflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

// File: design/mwsm_back.sv
module mwsm_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  mwsm_pkg::wheel_item_type in_item,
   input  mwsm_pkg::cfg_type cfg,
   output logic rsp_valid,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_front_a,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_front_b,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_back_a,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_back_b,
   output logic rsp_was_scaled
);
   import mwsm_pkg::*;

   // The scaled quotient never exceeds the rpm limit, so one bit per limit bit.
   localparam int STEPS = LIMIT_W;
   localparam int NUM_W = MAG_W + LIMIT_W;

   logic valid_ff [STEPS+1];
   wheel_item_type item_ff [STEPS+1];
   logic [MAG_W-1:0] rem_ff [STEPS+1][WHEELS];
   logic [STEPS-1:0] low_ff [STEPS+1][WHEELS];
   logic [STEPS-1:0] quo_ff [STEPS+1][WHEELS];

   logic [MAG_W-1:0] rem_in [STEPS+1][WHEELS];
   logic [STEPS-1:0] low_in [STEPS+1][WHEELS];
   logic [STEPS-1:0] quo_in [STEPS+1][WHEELS];
   logic [NUM_W-1:0] num_c [WHEELS];
   logic [MAG_W:0] trial_c [STEPS+1][WHEELS];
   logic [MAG_W:0] div_c;

   logic out_valid_ff;
   logic signed [MAG_W-1:0] out_ff [WHEELS];
   logic out_scaled_ff;
   logic [MAG_W-1:0] val_c [WHEELS];
   logic signed [MAG_W-1:0] res_c [WHEELS];

   // Restoring division, one quotient bit per stage, by the stage's own maximum.
   always_comb begin
      for (int l = 0; l < WHEELS; l++) begin
         num_c[l] = in_item.mag[l] * cfg.limit_wheel_rpm;
         rem_in[0][l] = num_c[l][NUM_W-1:STEPS];
         low_in[0][l] = num_c[l][STEPS-1:0];
         quo_in[0][l] = '0;
         trial_c[0][l] = '0;
      end
      for (int s = 1; s <= STEPS; s++) begin
         div_c = {1'b0, item_ff[s-1].maxm};
         for (int l = 0; l < WHEELS; l++) begin
            trial_c[s][l] = {rem_ff[s-1][l], low_ff[s-1][l][STEPS-1]};
            low_in[s][l] = {low_ff[s-1][l][STEPS-2:0], 1'b0};
            if (trial_c[s][l] >= div_c) begin
               rem_in[s][l] = MAG_W'(trial_c[s][l] - div_c);
               quo_in[s][l] = {quo_ff[s-1][l][STEPS-2:0], 1'b1};
            end else begin
               rem_in[s][l] = trial_c[s][l][MAG_W-1:0];
               quo_in[s][l] = {quo_ff[s-1][l][STEPS-2:0], 1'b0};
            end
         end
      end
      if (STEPS < 1) begin
         div_c = '0;
      end
   end

   always_comb begin
      for (int l = 0; l < WHEELS; l++) begin
         val_c[l] = item_ff[STEPS].scale ? MAG_W'(quo_ff[STEPS][l])
                                         : item_ff[STEPS].mag[l];
         res_c[l] = item_ff[STEPS].neg[l] ? MAG_W'(-val_c[l]) : val_c[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= in_item;
      for (int s = 1; s <= STEPS; s++) begin
         item_ff[s] <= item_ff[s-1];
      end
      for (int s = 0; s <= STEPS; s++) begin
         for (int l = 0; l < WHEELS; l++) begin
            rem_ff[s][l] <= rem_in[s][l];
            low_ff[s][l] <= low_in[s][l];
            quo_ff[s][l] <= quo_in[s][l];
         end
      end
      for (int l = 0; l < WHEELS; l++) begin
         out_ff[l] <= res_c[l];
      end
      out_scaled_ff <= item_ff[STEPS].scale;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rpm_front_a = out_ff[0];
   assign rsp_rpm_front_b = out_ff[1];
   assign rsp_rpm_back_a = out_ff[2];
   assign rsp_rpm_back_b = out_ff[3];
   assign rsp_was_scaled = out_scaled_ff;

   a_quo_le_limit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STEPS] && item_ff[STEPS].scale) |->
      ((quo_ff[STEPS][0] <= cfg.limit_wheel_rpm) && (quo_ff[STEPS][1] <= cfg.limit_wheel_rpm)
       && (quo_ff[STEPS][2] <= cfg.limit_wheel_rpm)
       && (quo_ff[STEPS][3] <= cfg.limit_wheel_rpm)))
      else $error("scaled wheel exceeds rpm limit");

   a_quo_le_mag: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STEPS] && item_ff[STEPS].scale) |->
      ((MAG_W'(quo_ff[STEPS][0]) <= item_ff[STEPS].mag[0])
       && (MAG_W'(quo_ff[STEPS][3]) <= item_ff[STEPS].mag[3])))
      else $error("scaling increased a wheel magnitude");

endmodule

// File: design/mecanum_wheel_speed_mixer.sv
// Four-wheel mecanum speed mixer.
// A request (forward speed, sideways speed, turn rate) is taken at a rising
// edge where start is high and busy is low. Each axis is clamped to its
// configured limit, mixed into four wheel rpm values, truncated and clipped
// to 16 bits; if the largest magnitude exceeds the rpm limit, all four are
// scaled by limit/max and rsp_was_scaled is set.
// One request per cycle is sustained while busy is low. Every request gives
// exactly one result after it is taken: six front pipeline stages, the
// request queue (write, then registered read), a load stage and a 15-stage
// restoring divider (one quotient bit per stage), then the output register.
// The result is on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot stall the block, so busy stays low in normal use.
// Configuration goes through the APB port at byte address 4*i and must be
// written only while no request is in flight. Reset clears the pipeline and
// queue and loads the register defaults.
module mecanum_wheel_speed_mixer #(
   parameter int RATIO_FRAC_BITS = mwsm_pkg::DEF_RATIO_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [mwsm_pkg::SPEED_W-1:0] req_speed_forward,
   input  logic signed [mwsm_pkg::SPEED_W-1:0] req_speed_sideways,
   input  logic signed [mwsm_pkg::SPEED_W-1:0] req_turn_rate,
   output logic rsp_valid,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_front_a,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_front_b,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_back_a,
   output logic signed [mwsm_pkg::MAG_W-1:0] rsp_rpm_back_b,
   output logic rsp_was_scaled,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mwsm_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import mwsm_pkg::*;

   localparam logic [RATIO_W-1:0] GAIN_RESET = RATIO_W'(64'd5 << RATIO_FRAC_BITS);
   localparam logic [RATIO_W-1:0] RPM_RESET = RATIO_W'(64'd1 << (RATIO_FRAC_BITS - 3));

   cfg_type cfg_ff, cfg_in;
   logic wr_en;
   logic accept;
   logic front_valid, queue_valid, queue_af;
   wheel_item_type front_item, queue_item;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   assign accept = start && !busy;
   assign busy = queue_af;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[4:2])
            REG_LIMIT_FORWARD: cfg_in.limit_forward = pwdata[LIMIT_W-1:0];
            REG_LIMIT_SIDEWAYS: cfg_in.limit_sideways = pwdata[LIMIT_W-1:0];
            REG_LIMIT_TURN: cfg_in.limit_turn = pwdata[LIMIT_W-1:0];
            REG_LIMIT_WHEEL_RPM: cfg_in.limit_wheel_rpm = pwdata[LIMIT_W-1:0];
            REG_TURN_GAIN_FRONT: cfg_in.turn_gain_front = pwdata;
            REG_TURN_GAIN_BACK: cfg_in.turn_gain_back = pwdata;
            REG_RPM_PER_SPEED: cfg_in.rpm_per_speed = pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_LIMIT_FORWARD: prdata = 32'(cfg_ff.limit_forward);
         REG_LIMIT_SIDEWAYS: prdata = 32'(cfg_ff.limit_sideways);
         REG_LIMIT_TURN: prdata = 32'(cfg_ff.limit_turn);
         REG_LIMIT_WHEEL_RPM: prdata = 32'(cfg_ff.limit_wheel_rpm);
         REG_TURN_GAIN_FRONT: prdata = cfg_ff.turn_gain_front;
         REG_TURN_GAIN_BACK: prdata = cfg_ff.turn_gain_back;
         REG_RPM_PER_SPEED: prdata = cfg_ff.rpm_per_speed;
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_forward <= LIMIT_FORWARD_RESET;
         cfg_ff.limit_sideways <= LIMIT_SIDEWAYS_RESET;
         cfg_ff.limit_turn <= LIMIT_TURN_RESET;
         cfg_ff.limit_wheel_rpm <= LIMIT_WHEEL_RPM_RESET;
         cfg_ff.turn_gain_front <= GAIN_RESET;
         cfg_ff.turn_gain_back <= GAIN_RESET;
         cfg_ff.rpm_per_speed <= RPM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mwsm_front #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(accept),
      .speed_forward(req_speed_forward),
      .speed_sideways(req_speed_sideways),
      .turn_rate(req_turn_rate),
      .cfg(cfg_ff),
      .out_valid(front_valid),
      .out_item(front_item)
   );

   mwsm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(front_valid),
      .push_item(front_item),
      .pop(1'b1),
      .pop_item(queue_item),
      .pop_valid(queue_valid),
      .almost_full(queue_af)
   );

   mwsm_back u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(queue_valid),
      .in_item(queue_item),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_rpm_front_a(rsp_rpm_front_a),
      .rsp_rpm_front_b(rsp_rpm_front_b),
      .rsp_rpm_back_a(rsp_rpm_back_a),
      .rsp_rpm_back_b(rsp_rpm_back_b),
      .rsp_was_scaled(rsp_was_scaled)
   );

endmodule
